@@ rtl/usbdsc_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// usbdsc_pkg
// Types, codes and helpers shared by the descriptor stream checker.
// ----------------------------------------------------------------------------
package usbdsc_pkg;

    localparam int COUNT_WIDTH = 16;
    localparam int TOTAL_WIDTH = 16;
    localparam int NUM_TYPES   = 256;

    localparam logic [7:0] DT_DEVICE    = 8'd1;
    localparam logic [7:0] DT_CONFIG    = 8'd2;
    localparam logic [7:0] DT_INTERFACE = 8'd4;
    localparam logic [7:0] DT_ENDPOINT  = 8'd5;

    localparam logic [7:0] LEN_HEADER   = 8'd2;
    localparam logic [7:0] LEN_DEVICE   = 8'd18;
    localparam logic [7:0] LEN_CONFIG   = 8'd9;
    localparam logic [7:0] LEN_IFACE    = 8'd9;
    localparam logic [7:0] LEN_EP_STD   = 8'd7;
    localparam logic [7:0] LEN_EP_AUDIO = 8'd9;

    typedef enum logic [1:0] {
        PH_LEN,
        PH_TYPE,
        PH_BODY,
        PH_DROP
    } t_phase;

    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_SHORT    = 3'd1,
        ST_SIZE     = 3'd2,
        ST_PART_HDR = 3'd3,
        ST_TRUNC    = 3'd4
    } t_status;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       stream_last;
    } t_in_item;

    typedef struct packed {
        logic [7:0]  descriptor_type;
        logic [7:0]  descriptor_length;
        logic [2:0]  status;
        logic [15:0] type_count;
        logic [15:0] bytes_processed;
        logic        stream_done;
    } t_out_item;

    // framed descriptor, passed from the framer to the count stage
    typedef struct packed {
        t_status                status;
        logic [7:0]             dtype;
        logic [7:0]             dlen;
        logic [TOTAL_WIDTH-1:0] total;
        logic                   last;
    } t_event;

    function automatic logic size_ok(input logic [7:0] dtype, input logic [7:0] dlen);
        logic ok;
        begin
            unique case (dtype)
                DT_DEVICE:    ok = (dlen == LEN_DEVICE);
                DT_CONFIG:    ok = (dlen == LEN_CONFIG);
                DT_INTERFACE: ok = (dlen == LEN_IFACE);
                DT_ENDPOINT:  ok = (dlen == LEN_EP_STD) || (dlen == LEN_EP_AUDIO);
                default:      ok = 1'b1;
            endcase
            return ok;
        end
    endfunction

endpackage

@@ rtl/usbdsc_framer.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// usbdsc_framer
// Frames the byte stream by length and type byte, checks sizes, keeps the
// per-stream byte total and flags each finished or failed descriptor.
// ----------------------------------------------------------------------------
module usbdsc_framer import usbdsc_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_fire,
    input  t_in_item i_item,
    output logic     o_ev_vld,
    output t_event   o_ev
);

    localparam int SUM_WIDTH = TOTAL_WIDTH + 1;

    t_phase                 r_phase, n_phase;
    logic [7:0]             r_len, n_len;
    logic [7:0]             r_type, n_type;
    logic [7:0]             r_rem, n_rem;
    logic [TOTAL_WIDTH-1:0] r_total, n_total;

    logic [7:0]             w_b;
    logic                   w_last;
    logic [7:0]             w_rem_dec;
    logic [7:0]             w_fin_type;
    logic                   w_size_ok;
    logic [SUM_WIDTH-1:0]   w_sum;
    logic [TOTAL_WIDTH-1:0] w_total_sat;

    assign w_b        = i_item.data_byte;
    assign w_last     = i_item.stream_last;
    assign w_rem_dec  = (r_rem != 8'd0) ? r_rem - 8'd1 : r_rem;
    assign w_fin_type = (r_phase == PH_TYPE) ? w_b : r_type;
    assign w_size_ok  = size_ok(w_fin_type, r_len);
    assign w_sum      = SUM_WIDTH'(r_total) + SUM_WIDTH'(r_len);
    assign w_total_sat = w_sum[TOTAL_WIDTH] ? {TOTAL_WIDTH{1'b1}} : w_sum[TOTAL_WIDTH-1:0];

    // next state
    always_comb begin
        n_phase = r_phase;
        n_len   = r_len;
        n_type  = r_type;
        n_rem   = r_rem;
        n_total = r_total;
        unique case (r_phase)
            PH_LEN: begin
                n_len   = w_b;
                n_type  = 8'd0;
                n_phase = PH_TYPE;
            end
            PH_TYPE: begin
                n_type = w_b;
                if (r_len < LEN_HEADER) begin
                    n_phase = PH_DROP;
                end else if (r_len == LEN_HEADER) begin
                    if (w_size_ok) begin
                        n_total = w_total_sat;
                        n_phase = PH_LEN;
                    end else begin
                        n_phase = PH_DROP;
                    end
                end else begin
                    n_rem   = r_len - LEN_HEADER;
                    n_phase = PH_BODY;
                end
            end
            PH_BODY: begin
                n_rem = w_rem_dec;
                if (w_rem_dec == 8'd0) begin
                    if (w_size_ok) begin
                        n_total = w_total_sat;
                        n_phase = PH_LEN;
                    end else begin
                        n_phase = PH_DROP;
                    end
                end
            end
            PH_DROP: begin
                n_phase = PH_DROP;
            end
            default: begin
                n_phase = PH_LEN;
            end
        endcase
        // stream end overrides everything
        if (w_last) begin
            n_phase = PH_LEN;
            n_total = '0;
            n_rem   = 8'd0;
        end
    end

    // event outputs
    always_comb begin
        o_ev_vld     = 1'b0;
        o_ev.status  = ST_OK;
        o_ev.dtype   = r_type;
        o_ev.dlen    = r_len;
        o_ev.total   = r_total;
        o_ev.last    = w_last;
        unique case (r_phase)
            PH_LEN: begin
                o_ev.dtype = 8'd0;
                o_ev.dlen  = w_b;
                if (w_last) begin
                    o_ev_vld    = 1'b1;
                    o_ev.status = ST_PART_HDR;
                end
            end
            PH_TYPE: begin
                o_ev.dtype = w_b;
                if (r_len < LEN_HEADER) begin
                    o_ev_vld    = 1'b1;
                    o_ev.status = ST_SHORT;
                end else if (r_len == LEN_HEADER) begin
                    o_ev_vld    = 1'b1;
                    o_ev.status = w_size_ok ? ST_OK : ST_SIZE;
                    o_ev.total  = w_size_ok ? w_total_sat : r_total;
                end else if (w_last) begin
                    o_ev_vld    = 1'b1;
                    o_ev.status = ST_TRUNC;
                end
            end
            PH_BODY: begin
                if (w_rem_dec == 8'd0) begin
                    o_ev_vld    = 1'b1;
                    o_ev.status = w_size_ok ? ST_OK : ST_SIZE;
                    o_ev.total  = w_size_ok ? w_total_sat : r_total;
                end else if (w_last) begin
                    o_ev_vld    = 1'b1;
                    o_ev.status = ST_TRUNC;
                end
            end
            default: begin
                o_ev_vld = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_LEN;
            r_len   <= 8'd0;
            r_type  <= 8'd0;
            r_rem   <= 8'd0;
            r_total <= '0;
        end else if (i_fire) begin
            r_phase <= n_phase;
            r_len   <= n_len;
            r_type  <= n_type;
            r_rem   <= n_rem;
            r_total <= n_total;
        end
    end

endmodule

@@ rtl/usbdsc_counts.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// usbdsc_counts
// Per-type descriptor counters: read at event load, saturating increment
// and write back of OK results when the result moves on. Valid bits stand for reset zero.
// ----------------------------------------------------------------------------
module usbdsc_counts import usbdsc_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_load,
    input  t_event    i_ev,
    input  logic      i_adv,
    output logic      o_vld,
    output t_out_item o_item
);

    logic [COUNT_WIDTH-1:0] r_mem [NUM_TYPES];
    logic [NUM_TYPES-1:0]   r_cnt_vld;

    logic                   r_ev_vld;
    t_event                 r_ev;
    logic [COUNT_WIDTH-1:0] r_mem_q;
    logic                   r_vld_q;
    logic                   r_fwd;
    logic [COUNT_WIDTH-1:0] r_fwd_data;

    logic                   w_wr_en;
    logic [COUNT_WIDTH-1:0] w_cnt_cur;
    logic [COUNT_WIDTH-1:0] w_cnt_next;

    assign w_cnt_cur  = r_fwd ? r_fwd_data : (r_vld_q ? r_mem_q : '0);
    assign w_cnt_next = (r_ev.status != ST_OK || w_cnt_cur == {COUNT_WIDTH{1'b1}})
                        ? w_cnt_cur : w_cnt_cur + 1'b1;
    assign w_wr_en    = r_ev_vld && i_adv && (r_ev.status == ST_OK);

    always_ff @(posedge i_clk) begin
        if (w_wr_en) begin
            r_mem[r_ev.dtype] <= w_cnt_next;
        end
        if (i_load) begin
            r_mem_q    <= r_mem[i_ev.dtype];
            r_vld_q    <= r_cnt_vld[i_ev.dtype];
            r_fwd      <= w_wr_en && (r_ev.dtype == i_ev.dtype);
            r_fwd_data <= w_cnt_next;
            r_ev       <= i_ev;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt_vld <= '0;
            r_ev_vld  <= 1'b0;
        end else begin
            if (w_wr_en) begin
                r_cnt_vld[r_ev.dtype] <= 1'b1;
            end
            if (i_load) begin
                r_ev_vld <= 1'b1;
            end else if (i_adv) begin
                r_ev_vld <= 1'b0;
            end
        end
    end

    assign o_vld                    = r_ev_vld;
    assign o_item.descriptor_type   = r_ev.dtype;
    assign o_item.descriptor_length = r_ev.dlen;
    assign o_item.status            = r_ev.status;
    assign o_item.type_count        = 16'(w_cnt_next);
    assign o_item.bytes_processed   = 16'(r_ev.total);
    assign o_item.stream_done       = r_ev.last;

endmodule

@@ rtl/usb_descriptor_stream_checker_unit.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// usb_descriptor_stream_checker_unit
// Frames a descriptor byte stream, checks each descriptor and reports one
// result per finished or failed descriptor with per-type counts.
// ----------------------------------------------------------------------------
//  channel | dir | handshake                | payload
//  in      | in  | i_in_valid / o_in_stall   | i_in_data  (t_in_item)
//  out     | out | o_out_valid / i_out_stall | o_out_data (t_out_item)
//
//  One byte per cycle while o_in_stall is low. A result passes from the input
//  register to the count stage and from the count stage to the output register.
//  The type counter read-modify-write sits in the count stage; a write and
//  the following read of the same type are forwarded.
//  Reset clears state and the 256 counter valid bits.
//  Bytes without a result pass through even while the output is stalled.
// ----------------------------------------------------------------------------
module usb_descriptor_stream_checker_unit import usbdsc_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_stall,
    input  t_in_item  i_in_data,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_out_item o_out_data
);

    logic      r_in_vld;
    t_in_item  r_in;
    logic      r_out_vld;
    t_out_item r_out;

    logic      w_adv_out;
    logic      w_adv2;
    logic      w_fire1;
    logic      w_ev_vld;
    t_event    w_ev;
    logic      w_ev2_vld;
    t_out_item w_item2;

    assign w_adv_out  = !r_out_vld || !i_out_stall;
    assign w_adv2     = !w_ev2_vld || w_adv_out;
    assign w_fire1    = r_in_vld && (!w_ev_vld || w_adv2);
    assign o_in_stall = r_in_vld && !w_fire1;

    usbdsc_framer u_framer (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_fire   (w_fire1),
        .i_item   (r_in),
        .o_ev_vld (w_ev_vld),
        .o_ev     (w_ev)
    );

    usbdsc_counts u_counts (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (w_fire1 && w_ev_vld),
        .i_ev    (w_ev),
        .i_adv   (w_adv_out),
        .o_vld   (w_ev2_vld),
        .o_item  (w_item2)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (i_in_valid && !o_in_stall) begin
            r_in_vld <= 1'b1;
        end else if (w_fire1) begin
            r_in_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && !o_in_stall) begin
            r_in <= i_in_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (w_adv_out) begin
            r_out_vld <= w_ev2_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv_out && w_ev2_vld) begin
            r_out <= w_item2;
        end
    end

    assign o_out_valid = r_out_vld;
    assign o_out_data  = r_out;

endmodule
